/* rtl/ntf_pkg.sv */
package ntf_pkg;

    // Default limit on the characters sent out for one number.
    localparam int MAX_CHARS_DEF = 16;

    // A 32-bit magnitude has at most ten decimal digits.
    // In base 26 it has at most seven.
    localparam int DIG_DEPTH = 10;
    localparam int DIG_IDX_W = $clog2(DIG_DEPTH);

    // Style codes. Codes above STYLE_UPPER_ALPHA format as decimal.
    localparam logic [2:0] STYLE_DECIMAL     = 3'd0;
    localparam logic [2:0] STYLE_LOWER_ROMAN = 3'd1;
    localparam logic [2:0] STYLE_UPPER_ROMAN = 3'd2;
    localparam logic [2:0] STYLE_LOWER_ALPHA = 3'd3;
    localparam logic [2:0] STYLE_UPPER_ALPHA = 3'd4;

    localparam logic [31:0] ROMAN_LIMIT = 32'd39999;

    // Reciprocals for constant division: q = (x * RECIP) >> SHIFT.
    // Each is exact for every 32-bit x.
    localparam logic [31:0] RECIP_10 = 32'd3435973837;
    localparam int          SHIFT_10 = 35;
    localparam logic [31:0] RECIP_26 = 32'd2643056798;
    localparam int          SHIFT_26 = 36;

    localparam logic [6:0] ASCII_MINUS   = 7'h2D;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         style;
        logic [4:0]         min_digits;
    } num_word_t;

    typedef struct packed {
        logic [6:0] text_char;
        logic       last;
        logic       range_error;
    } txt_word_t;

    // Roman letter for a decimal position. The "one" letters are i x c m z.
    // The "five" letters are v l d w.
    function automatic logic [6:0] roman_letter(input logic five, input logic [2:0] pos,
                                                input logic upper);
        logic [6:0] lc;
        begin
            lc = 7'h69;
            if (five)
            begin
                case (pos)
                    3'd0:    lc = 7'h76;
                    3'd1:    lc = 7'h6C;
                    3'd2:    lc = 7'h64;
                    default: lc = 7'h77;
                endcase
            end
            else
            begin
                case (pos)
                    3'd0:    lc = 7'h69;
                    3'd1:    lc = 7'h78;
                    3'd2:    lc = 7'h63;
                    3'd3:    lc = 7'h6D;
                    default: lc = 7'h7A;
                endcase
            end
            roman_letter = upper ? (lc & 7'h5F) : lc;
        end
    endfunction

endpackage

/* rtl/ntf_div.sv */
module ntf_div (
    input  logic        clk,
    input  logic        mul_en,
    input  logic        base26,
    input  logic [31:0] x,
    output logic [31:0] quot,
    output logic [4:0]  rem
);
    import ntf_pkg::*;

    logic [63:0] prod;
    logic [31:0] recip;
    logic [31:0] quot_reg;
    logic [31:0] quot_next;
    logic [4:0]  back;

    // The quotient is taken from the high bits of the reciprocal product.
    always_comb
    begin
        recip = base26 ? RECIP_26 : RECIP_10;
        prod  = 64'(x) * 64'(recip);
        if (base26)
        begin
            quot_next = 32'(prod[63:SHIFT_26]);
        end
        else
        begin
            quot_next = 32'(prod[63:SHIFT_10]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            quot_reg <= quot_next;
        end
    end

    // The remainder is below 26, so five low bits of x - q * base are enough.
    always_comb
    begin
        if (base26)
        begin
            back = 5'((quot_reg[4:0] << 4) + (quot_reg[4:0] << 3) + (quot_reg[4:0] << 1));
        end
        else
        begin
            back = 5'((quot_reg[4:0] << 3) + (quot_reg[4:0] << 1));
        end
        rem = 5'(x[4:0] - back);
    end

    assign quot = quot_reg;

endmodule

/* rtl/number_to_text_formatter.sv */
// Formats one signed 32-bit number per input word as ASCII text. The text goes out
// one character per output word, most significant first. The last character of a
// number has last set. Styles are decimal (zero padded to min_digits), lower or
// upper roman (z and w stand for ten and five thousand), and lower or upper
// bijective base-26 letters. Codes 5 to 7 are decimal. A negative number gets a
// leading minus sign. Zero prints as 0 in the roman and letter styles. At most
// MAX_CHARS characters go out, and the last of them carries last. A roman
// magnitude above 39999 gives a single word with range_error set and text_char zero.
// The block handles one number at a time, and num_ready stays low until every
// character of that number has been handed to the output register. After an
// item is accepted, the shared constant divider produces one digit per pass
// through its multiply and subtract steps: up to ten for decimal, seven for
// letters and five for roman. The sign, pad and digit steps then write the text
// into the character buffer, one character at a time. The emit step then reads
// the text out at one character per cycle when txt_ready is held high. The
// division loop runs through a single 32x32 reciprocal multiplier, and the
// character buffer has one write port.
module number_to_text_formatter #(
    parameter int MAX_CHARS = ntf_pkg::MAX_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              num_valid,
    output logic              num_ready,
    input  ntf_pkg::num_word_t num,
    output logic              txt_valid,
    input  logic              txt_ready,
    output ntf_pkg::txt_word_t txt
);
    import ntf_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHARS);
    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    // The number moves through these steps. The divider splits the magnitude into
    // digits, least significant first. The sign, pad and digit steps then write
    // the text into the character buffer. The emit step reads the text out.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_SUB,
        ST_SIGN,
        ST_PAD,
        ST_DIGS,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         x_reg, x_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic                roman_reg, roman_next;
    logic                alpha_reg, alpha_next;
    logic                upper_reg, upper_next;
    logic                err_reg, err_next;
    logic [4:0]          min_reg, min_next;
    logic [4:0]          pad_reg, pad_next;
    logic [DIG_IDX_W:0]  nd_reg, nd_next;
    logic [DIG_IDX_W-1:0] dptr_reg, dptr_next;
    logic [1:0]          rsub_reg, rsub_next;
    logic [CNT_W-1:0]    wr_reg, wr_next;
    logic [IDX_W-1:0]    rd_reg, rd_next;
    logic                txt_valid_reg, txt_valid_next;
    txt_word_t           txt_reg, txt_next;

    // Digit store (LSB first) and character buffer.
    logic [4:0]          dig_reg [DIG_DEPTH];
    logic [6:0]          buf_reg [MAX_CHARS];
    logic                dig_we;
    logic                buf_we;
    logic [6:0]          buf_wdata;

    // Shared divider.
    logic                div_mul_en;
    logic [31:0]         div_quot;
    logic [4:0]          div_rem;

    // Decode of the incoming word.
    logic                in_neg;
    logic [31:0]         in_mag;
    logic                in_roman;
    logic                in_alpha;
    logic                in_upper;

    // Digit the build steps are working on.
    logic [4:0]          cur_dig;
    logic [2:0]          rom_len;
    logic [6:0]          rom_char;
    logic [2:0]          pos;
    logic [4:0]          nd_ext;

    ntf_div u_div (
        .clk    (clk),
        .mul_en (div_mul_en),
        .base26 (alpha_reg),
        .x      (x_reg),
        .quot   (div_quot),
        .rem    (div_rem)
    );

    always_comb
    begin
        in_neg   = num.value[31];
        in_mag   = in_neg ? (32'd0 - 32'(num.value)) : 32'(num.value);
        in_roman = (num.style == STYLE_LOWER_ROMAN) || (num.style == STYLE_UPPER_ROMAN);
        in_alpha = (num.style == STYLE_LOWER_ALPHA) || (num.style == STYLE_UPPER_ALPHA);
        in_upper = (num.style == STYLE_UPPER_ROMAN) || (num.style == STYLE_UPPER_ALPHA);
    end

    // A roman position that lies above the digits produced reads as zero.
    always_comb
    begin
        pos = 3'(dptr_reg);
        if ((DIG_IDX_W + 1)'(dptr_reg) < nd_reg)
        begin
            cur_dig = dig_reg[dptr_reg];
        end
        else
        begin
            cur_dig = 5'd0;
        end

        if (pos == 3'd4)
        begin
            rom_len = 3'(cur_dig);
        end
        else
        begin
            case (cur_dig)
                5'd0:    rom_len = 3'd0;
                5'd1:    rom_len = 3'd1;
                5'd2:    rom_len = 3'd2;
                5'd3:    rom_len = 3'd3;
                5'd4:    rom_len = 3'd2;
                5'd5:    rom_len = 3'd1;
                5'd6:    rom_len = 3'd2;
                5'd7:    rom_len = 3'd3;
                5'd8:    rom_len = 3'd4;
                default: rom_len = 3'd2;
            endcase
        end

        // The subtractive forms are four (one then five) and nine (one then the
        // next one). Other digits are an optional five followed by ones.
        if (pos == 3'd4)
        begin
            rom_char = roman_letter(1'b0, pos, upper_reg);
        end
        else if (cur_dig == 5'd4)
        begin
            rom_char = roman_letter(rsub_reg != 2'd0, pos, upper_reg);
        end
        else if (cur_dig == 5'd9)
        begin
            rom_char = roman_letter(1'b0, (rsub_reg == 2'd0) ? pos : pos + 3'd1, upper_reg);
        end
        else if (cur_dig >= 5'd5)
        begin
            rom_char = roman_letter(rsub_reg == 2'd0, pos, upper_reg);
        end
        else
        begin
            rom_char = roman_letter(1'b0, pos, upper_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        roman_next     = roman_reg;
        alpha_next     = alpha_reg;
        upper_next     = upper_reg;
        err_next       = err_reg;
        min_next       = min_reg;
        pad_next       = pad_reg;
        nd_next        = nd_reg;
        dptr_next      = dptr_reg;
        rsub_next      = rsub_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        txt_next       = txt_reg;
        txt_valid_next = txt_valid_reg && !txt_ready;
        dig_we         = 1'b0;
        buf_we         = 1'b0;
        buf_wdata      = ASCII_ZERO;
        div_mul_en     = 1'b0;
        nd_ext         = 5'(nd_reg) + 5'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (num_valid)
                begin
                    neg_next   = in_neg;
                    roman_next = in_roman;
                    alpha_next = in_alpha;
                    upper_next = in_upper;
                    min_next   = num.min_digits;
                    zero_next  = (in_roman || in_alpha) && (in_mag == 32'd0);
                    err_next   = 1'b0;
                    nd_next    = '0;
                    pad_next   = 5'd0;
                    rsub_next  = 2'd0;
                    wr_next    = '0;
                    rd_next    = '0;
                    if (in_roman && (in_mag > ROMAN_LIMIT))
                    begin
                        // Overflow sends one error word and nothing else.
                        err_next   = 1'b1;
                        wr_next    = CNT_W'(1);
                        state_next = ST_EMIT;
                    end
                    else if ((in_roman || in_alpha) && (in_mag == 32'd0))
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        // Bijective base 26 starts from the magnitude minus one.
                        x_next     = in_alpha ? (in_mag - 32'd1) : in_mag;
                        state_next = ST_DIV_MUL;
                    end
                end
            end

            ST_DIV_MUL:
            begin
                div_mul_en = 1'b1;
                state_next = ST_DIV_SUB;
            end

            ST_DIV_SUB:
            begin
                dig_we  = 1'b1;
                nd_next = nd_reg + (DIG_IDX_W + 1)'(1);
                if (div_quot == 32'd0)
                begin
                    // Roman text always walks the five positions from the top.
                    dptr_next = roman_reg ? DIG_IDX_W'(4) : nd_reg[DIG_IDX_W-1:0];
                    pad_next  = (min_reg > nd_ext) ? (min_reg - nd_ext) : 5'd0;
                    state_next = ST_SIGN;
                end
                else
                begin
                    x_next     = alpha_reg ? (div_quot - 32'd1) : div_quot;
                    state_next = ST_DIV_MUL;
                end
            end

            ST_SIGN:
            begin
                if (neg_reg)
                begin
                    buf_we    = 1'b1;
                    buf_wdata = ASCII_MINUS;
                    wr_next   = wr_reg + CNT_W'(1);
                end
                state_next = (roman_reg || alpha_reg) ? ST_DIGS : ST_PAD;
            end

            ST_PAD:
            begin
                if (wr_reg == CNT_W'(MAX_CHARS))
                begin
                    state_next = ST_EMIT;
                end
                else if (pad_reg != 5'd0)
                begin
                    buf_we    = 1'b1;
                    buf_wdata = ASCII_ZERO;
                    wr_next   = wr_reg + CNT_W'(1);
                    pad_next  = pad_reg - 5'd1;
                end
                else
                begin
                    state_next = ST_DIGS;
                end
            end

            ST_DIGS:
            begin
                if (wr_reg == CNT_W'(MAX_CHARS))
                begin
                    state_next = ST_EMIT;
                end
                else if (zero_reg)
                begin
                    buf_we     = 1'b1;
                    buf_wdata  = ASCII_ZERO;
                    wr_next    = wr_reg + CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else if (roman_reg)
                begin
                    if (rom_len != 3'd0)
                    begin
                        buf_we    = 1'b1;
                        buf_wdata = rom_char;
                        wr_next   = wr_reg + CNT_W'(1);
                    end
                    if ((rom_len == 3'd0) || (3'(rsub_reg) == rom_len - 3'd1))
                    begin
                        rsub_next = 2'd0;
                        if (dptr_reg == '0)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            dptr_next = dptr_reg - DIG_IDX_W'(1);
                        end
                    end
                    else
                    begin
                        rsub_next = rsub_reg + 2'd1;
                    end
                end
                else
                begin
                    buf_we = 1'b1;
                    if (alpha_reg)
                    begin
                        buf_wdata = (upper_reg ? ASCII_UPPER_A : ASCII_LOWER_A) + 7'(cur_dig);
                    end
                    else
                    begin
                        buf_wdata = ASCII_ZERO + 7'(cur_dig);
                    end
                    wr_next = wr_reg + CNT_W'(1);
                    if (dptr_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        dptr_next = dptr_reg - DIG_IDX_W'(1);
                    end
                end
            end

            ST_EMIT:
            begin
                // The output register refills as soon as the held word is taken.
                if (!txt_valid_reg || txt_ready)
                begin
                    txt_valid_next        = 1'b1;
                    txt_next.text_char    = err_reg ? 7'd0 : buf_reg[rd_reg];
                    txt_next.range_error  = err_reg;
                    txt_next.last         = (CNT_W'(rd_reg) + CNT_W'(1) == wr_reg);
                    if (CNT_W'(rd_reg) + CNT_W'(1) == wr_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_next = rd_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            roman_reg     <= 1'b0;
            alpha_reg     <= 1'b0;
            upper_reg     <= 1'b0;
            err_reg       <= 1'b0;
            min_reg       <= '0;
            pad_reg       <= '0;
            nd_reg        <= '0;
            dptr_reg      <= '0;
            rsub_reg      <= '0;
            wr_reg        <= '0;
            rd_reg        <= '0;
            txt_valid_reg <= 1'b0;
            txt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            neg_reg       <= neg_next;
            zero_reg      <= zero_next;
            roman_reg     <= roman_next;
            alpha_reg     <= alpha_next;
            upper_reg     <= upper_next;
            err_reg       <= err_next;
            min_reg       <= min_next;
            pad_reg       <= pad_next;
            nd_reg        <= nd_next;
            dptr_reg      <= dptr_next;
            rsub_reg      <= rsub_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            txt_valid_reg <= txt_valid_next;
            txt_reg       <= txt_next;
        end
    end

    // The digit store and the character buffer need no reset. Each is written
    // before it is read for the current number.
    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            dig_reg[nd_reg[DIG_IDX_W-1:0]] <= div_rem;
        end
        if (buf_we)
        begin
            buf_reg[wr_reg[IDX_W-1:0]] <= buf_wdata;
        end
    end

    assign num_ready = (state_reg == ST_IDLE);
    assign txt_valid = txt_valid_reg;
    assign txt       = txt_reg;

endmodule
